@@ sv/c8ic_pkg.sv @@
// ----------------------------------------------------------------------------
// c8ic_pkg
// Shared types, micro-operation codes, opcode fields and the font table
// for the chip8 interpreter core.
// ----------------------------------------------------------------------------
`default_nettype none

package c8ic_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int ADDR_W        = 12;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ROW_W         = 5;
    localparam int STACK_DEPTH   = 16;
    localparam int FONT_BYTES    = 80;

    localparam logic [ADDR_W-1:0] START_ADDR = 12'h200;

    // request operations
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // controller states, also sent to the datapath as micro-operation
    localparam int UOP_W = 5;
    localparam logic [UOP_W-1:0] U_CLR   = 5'd0;
    localparam logic [UOP_W-1:0] U_IDLE  = 5'd1;
    localparam logic [UOP_W-1:0] U_LOAD  = 5'd2;
    localparam logic [UOP_W-1:0] U_RROW0 = 5'd3;
    localparam logic [UOP_W-1:0] U_RROW1 = 5'd4;
    localparam logic [UOP_W-1:0] U_F0    = 5'd5;
    localparam logic [UOP_W-1:0] U_F1    = 5'd6;
    localparam logic [UOP_W-1:0] U_F2    = 5'd7;
    localparam logic [UOP_W-1:0] U_F3    = 5'd8;
    localparam logic [UOP_W-1:0] U_F4    = 5'd9;
    localparam logic [UOP_W-1:0] U_EXEC  = 5'd10;
    localparam logic [UOP_W-1:0] U_CLS   = 5'd11;
    localparam logic [UOP_W-1:0] U_BCD   = 5'd12;
    localparam logic [UOP_W-1:0] U_STO   = 5'd13;
    localparam logic [UOP_W-1:0] U_LD0   = 5'd14;
    localparam logic [UOP_W-1:0] U_LD1   = 5'd15;
    localparam logic [UOP_W-1:0] U_SPR0  = 5'd16;
    localparam logic [UOP_W-1:0] U_SPR1  = 5'd17;
    localparam logic [UOP_W-1:0] U_SPRF  = 5'd18;
    localparam logic [UOP_W-1:0] U_TICK  = 5'd19;
    localparam logic [UOP_W-1:0] U_OUT   = 5'd20;

    // instruction groups (top nibble)
    localparam logic [3:0] N_SYS  = 4'h0;
    localparam logic [3:0] N_JP   = 4'h1;
    localparam logic [3:0] N_CALL = 4'h2;
    localparam logic [3:0] N_SEI  = 4'h3;
    localparam logic [3:0] N_SNEI = 4'h4;
    localparam logic [3:0] N_SER  = 4'h5;
    localparam logic [3:0] N_LDI  = 4'h6;
    localparam logic [3:0] N_ADDI = 4'h7;
    localparam logic [3:0] N_ALU  = 4'h8;
    localparam logic [3:0] N_SNER = 4'h9;
    localparam logic [3:0] N_LDX  = 4'hA;
    localparam logic [3:0] N_JPV  = 4'hB;
    localparam logic [3:0] N_RND  = 4'hC;
    localparam logic [3:0] N_DRW  = 4'hD;
    localparam logic [3:0] N_KEY  = 4'hE;
    localparam logic [3:0] N_MISC = 4'hF;

    // alu sub-operations
    localparam logic [3:0] A_MOV = 4'h0;
    localparam logic [3:0] A_OR  = 4'h1;
    localparam logic [3:0] A_AND = 4'h2;
    localparam logic [3:0] A_XOR = 4'h3;
    localparam logic [3:0] A_ADD = 4'h4;
    localparam logic [3:0] A_SUB = 4'h5;
    localparam logic [3:0] A_SHR = 4'h6;
    localparam logic [3:0] A_SBN = 4'h7;
    localparam logic [3:0] A_SHL = 4'hE;

    // low-byte selectors
    localparam logic [7:0] K_CLS  = 8'hE0;
    localparam logic [7:0] K_RET  = 8'hEE;
    localparam logic [7:0] K_SKP  = 8'h9E;
    localparam logic [7:0] K_SKNP = 8'hA1;
    localparam logic [7:0] K_GDT  = 8'h07;
    localparam logic [7:0] K_WKEY = 8'h0A;
    localparam logic [7:0] K_SDT  = 8'h15;
    localparam logic [7:0] K_SST  = 8'h18;
    localparam logic [7:0] K_ADDX = 8'h1E;
    localparam logic [7:0] K_FONT = 8'h29;
    localparam logic [7:0] K_BCD  = 8'h33;
    localparam logic [7:0] K_STO  = 8'h55;
    localparam logic [7:0] K_LDM  = 8'h65;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [UOP_W-1:0] uop;
        logic             latch;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_op;
        logic [3:0] nib;
        logic [7:0] kk;
        logic       clr_last;
        logic       fb_last;
        logic       bcd_last;
        logic       cnt_eq_x;
        logic       spr_end;
    } sts_t;

endpackage

`default_nettype wire

@@ sv/c8ic_if.sv @@
// ----------------------------------------------------------------------------
// c8ic request and result channels
// Valid/ready channels carrying the request item and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface c8ic_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [11:0] address;
    logic [7:0]  data;
    logic [15:0] keys;
    logic [7:0]  random_byte;

    modport source (output valid, operation, address, data, keys, random_byte,
                    input ready);
    modport sink   (input valid, operation, address, data, keys, random_byte,
                    output ready);
endinterface

interface c8ic_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] display_row;
    logic [11:0] program_counter;
    logic        draw_done;
    logic        sound_on;
    logic        waiting_key;

    modport source (output valid, display_row, program_counter, draw_done,
                    sound_on, waiting_key, input ready);
    modport sink   (input valid, display_row, program_counter, draw_done,
                    sound_on, waiting_key, output ready);
endinterface

`default_nettype wire

@@ sv/c8ic_ctrl.sv @@
// ----------------------------------------------------------------------------
// c8ic_ctrl
// Sequencer: steps through fetch, decode, execute and the multi-cycle loops.
// ----------------------------------------------------------------------------
`default_nettype none

module c8ic_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    input  wire c8ic_pkg::sts_t sts,
    output c8ic_pkg::cmd_t     cmd
);
    import c8ic_pkg::*;

    logic [UOP_W-1:0] state_reg;
    logic [UOP_W-1:0] state_next;

    assign req_ready = (state_reg == U_IDLE);
    assign rsp_valid = (state_reg == U_OUT);
    assign cmd.uop   = state_reg;
    assign cmd.latch = req_ready && req_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            U_CLR:   if (sts.clr_last) state_next = U_IDLE;
            U_IDLE:
            begin
                if (req_valid)
                begin
                    case (sts.req_op)
                        OP_LOAD: state_next = U_LOAD;
                        OP_STEP: state_next = U_F0;
                        OP_READ: state_next = U_RROW0;
                        default: state_next = U_OUT;
                    endcase
                end
            end
            U_LOAD:  state_next = U_OUT;
            U_RROW0: state_next = U_RROW1;
            U_RROW1: state_next = U_OUT;
            U_F0:    state_next = U_F1;
            U_F1:    state_next = U_F2;
            U_F2:    state_next = U_F3;
            U_F3:    state_next = U_F4;
            U_F4:
            begin
                if (sts.nib == N_SYS && sts.kk == K_CLS)
                    state_next = U_CLS;
                else if (sts.nib == N_DRW)
                    state_next = U_SPR0;
                else if (sts.nib == N_MISC && sts.kk == K_BCD)
                    state_next = U_BCD;
                else if (sts.nib == N_MISC && sts.kk == K_STO)
                    state_next = U_STO;
                else if (sts.nib == N_MISC && sts.kk == K_LDM)
                    state_next = U_LD0;
                else
                    state_next = U_EXEC;
            end
            U_EXEC:  state_next = U_TICK;
            U_CLS:   if (sts.fb_last) state_next = U_TICK;
            U_BCD:   if (sts.bcd_last) state_next = U_TICK;
            U_STO:   if (sts.cnt_eq_x) state_next = U_TICK;
            U_LD0:   state_next = U_LD1;
            U_LD1:   state_next = sts.cnt_eq_x ? U_TICK : U_LD0;
            U_SPR0:  state_next = sts.spr_end ? U_SPRF : U_SPR1;
            U_SPR1:  state_next = U_SPR0;
            U_SPRF:  state_next = U_TICK;
            U_TICK:  state_next = U_OUT;
            U_OUT:   if (rsp_ready) state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= U_CLR;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ sv/c8ic_dp.sv @@
// ----------------------------------------------------------------------------
// c8ic_dp
// Datapath: program memory, frame buffer, registers, stack, timers and
// the execute logic driven by the sequencer's micro-operation.
// ----------------------------------------------------------------------------
`default_nettype none

module c8ic_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire c8ic_pkg::cmd_t cmd,
    output c8ic_pkg::sts_t      sts,
    input  wire logic [1:0]     operation,
    input  wire logic [11:0]    address,
    input  wire logic [7:0]     data,
    input  wire logic [15:0]    keys,
    input  wire logic [7:0]     random_byte,
    output logic [63:0]         display_row,
    output logic [11:0]         program_counter,
    output logic                draw_done,
    output logic                sound_on,
    output logic                waiting_key
);
    import c8ic_pkg::*;

    logic [7:0]  mem [MEM_BYTES];
    logic [63:0] fb [SCREEN_HEIGHT];
    logic [7:0]  regs_reg [16];
    logic [11:0] stack_reg [STACK_DEPTH];

    logic [11:0] clr_reg;
    logic [11:0] pc_reg, pc_next;
    logic [11:0] idx_reg, idx_next;
    logic [3:0]  sp_reg, sp_next;
    logic [7:0]  dt_reg, dt_next;
    logic [7:0]  st_reg, st_next;
    logic [15:0] op_reg;
    logic [7:0]  a_reg, b_reg;
    logic [4:0]  cnt_reg;
    logic        hit_reg;
    logic [11:0] addr_reg;
    logic [7:0]  data_reg, rnd_reg;
    logic [15:0] keys_reg;
    logic [63:0] row_reg;
    logic        draw_reg, wait_reg;
    logic [7:0]  mem_q;
    logic [63:0] fb_q;

    logic [3:0]  x, y, n;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [11:0] icnt;
    logic [5:0]  ysum;
    logic [63:0] mask;

    logic        mem_we;
    logic [11:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd;
    logic        fb_we;
    logic [4:0]  fb_wa, fb_ra;
    logic [63:0] fb_wd;

    logic [3:0]  ra;
    logic [7:0]  rd_data;
    logic        rw_en, vf_en;
    logic [3:0]  rw_addr;
    logic [7:0]  rw_data, vf_data;
    logic        push, wait_set;

    logic [1:0]  hund;
    logic [6:0]  rem;
    logic [14:0] tprod;
    logic [3:0]  tens, ones;
    logic [7:0]  digit;
    logic [8:0]  sum9;
    logic [3:0]  low_key;
    logic        key_found;
    logic        key_hit;

    assign x    = op_reg[11:8];
    assign y    = op_reg[7:4];
    assign n    = op_reg[3:0];
    assign kk   = op_reg[7:0];
    assign nnn  = op_reg[11:0];
    assign icnt = idx_reg + {7'd0, cnt_reg};
    assign ysum = {1'b0, b_reg[4:0]} + {1'b0, cnt_reg};
    assign mask = {mem_q, 56'd0} >> a_reg[5:0];

    assign sts.req_op   = operation;
    assign sts.nib      = op_reg[15:12];
    assign sts.kk       = kk;
    assign sts.clr_last = &clr_reg;
    assign sts.fb_last  = &cnt_reg;
    assign sts.bcd_last = (cnt_reg == 5'd2);
    assign sts.cnt_eq_x = (cnt_reg == {1'b0, x});
    assign sts.spr_end  = (cnt_reg == {1'b0, n}) || ysum[5];

    assign display_row     = row_reg;
    assign program_counter = pc_reg;
    assign draw_done       = draw_reg;
    assign sound_on        = (st_reg != 8'd0);
    assign waiting_key     = wait_reg;

    // bcd digits of vx
    always_comb
    begin
        if (a_reg >= 8'd200)
            hund = 2'd2;
        else if (a_reg >= 8'd100)
            hund = 2'd1;
        else
            hund = 2'd0;
        rem   = 7'(a_reg - 8'(hund * 7'd100));
        tprod = 15'(rem * 8'd205);
        tens  = 4'(tprod >> 11);
        ones  = 4'(rem - 7'(tens * 4'd10));
        case (cnt_reg[1:0])
            2'd0:    digit = {6'd0, hund};
            2'd1:    digit = {4'd0, tens};
            default: digit = {4'd0, ones};
        endcase
    end

    // lowest pressed key
    always_comb
    begin
        low_key   = 4'd0;
        key_found = 1'b0;
        for (int i = 15; i >= 0; i--)
        begin
            if (keys_reg[i])
            begin
                low_key   = 4'(i);
                key_found = 1'b1;
            end
        end
    end

    assign key_hit = (a_reg[7:4] == 4'd0) && keys_reg[a_reg[3:0]];
    assign sum9    = {1'b0, a_reg} + {1'b0, b_reg};

    // register file read address
    always_comb
    begin
        case (cmd.uop)
            U_F3:    ra = x;
            U_F4:    ra = (op_reg[15:12] == N_JPV) ? 4'd0 : y;
            default: ra = cnt_reg[3:0];
        endcase
    end
    assign rd_data = regs_reg[ra];

    // memory and frame buffer ports
    always_comb
    begin
        mem_ra = pc_reg;
        mem_we = 1'b0;
        mem_wa = icnt;
        mem_wd = rd_data;
        fb_ra  = ysum[4:0];
        fb_we  = 1'b0;
        fb_wa  = ysum[4:0];
        fb_wd  = fb_q ^ mask;
        case (cmd.uop)
            U_CLR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = (clr_reg < 12'(FONT_BYTES)) ? FONT_ROM[clr_reg[6:0]] : 8'd0;
                fb_we  = 1'b1;
                fb_wa  = clr_reg[4:0];
                fb_wd  = 64'd0;
            end
            U_LOAD:
            begin
                mem_we = 1'b1;
                mem_wa = addr_reg;
                mem_wd = data_reg;
            end
            U_RROW0: fb_ra = addr_reg[4:0];
            U_F1:    mem_ra = pc_reg + 12'd1;
            U_CLS:
            begin
                fb_we = 1'b1;
                fb_wa = cnt_reg;
                fb_wd = 64'd0;
            end
            U_BCD:
            begin
                mem_we = 1'b1;
                mem_wd = digit;
            end
            U_STO:   mem_we = 1'b1;
            U_LD0:   mem_ra = icnt;
            U_SPR0:  mem_ra = icnt;
            U_SPR1:  fb_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        mem_q <= mem[mem_ra];
        if (fb_we)
            fb[fb_wa] <= fb_wd;
        fb_q <= fb[fb_ra];
    end

    // execute
    always_comb
    begin
        pc_next  = pc_reg;
        idx_next = idx_reg;
        sp_next  = sp_reg;
        dt_next  = dt_reg;
        st_next  = st_reg;
        rw_en    = 1'b0;
        rw_addr  = x;
        rw_data  = 8'd0;
        vf_en    = 1'b0;
        vf_data  = 8'd0;
        push     = 1'b0;
        wait_set = 1'b0;
        case (cmd.uop)
            U_F2: pc_next = pc_reg + 12'd2;
            U_EXEC:
            begin
                case (op_reg[15:12])
                    N_SYS:
                    begin
                        if (kk == K_RET)
                        begin
                            sp_next = sp_reg - 4'd1;
                            pc_next = stack_reg[sp_reg - 4'd1];
                        end
                    end
                    N_JP:  pc_next = nnn;
                    N_CALL:
                    begin
                        push    = 1'b1;
                        sp_next = sp_reg + 4'd1;
                        pc_next = nnn;
                    end
                    N_SEI:  if (a_reg == kk) pc_next = pc_reg + 12'd2;
                    N_SNEI: if (a_reg != kk) pc_next = pc_reg + 12'd2;
                    N_SER:  if (a_reg == b_reg) pc_next = pc_reg + 12'd2;
                    N_LDI:
                    begin
                        rw_en   = 1'b1;
                        rw_data = kk;
                    end
                    N_ADDI:
                    begin
                        rw_en   = 1'b1;
                        rw_data = a_reg + kk;
                    end
                    N_ALU:
                    begin
                        rw_en = 1'b1;
                        case (n)
                            A_MOV: rw_data = b_reg;
                            A_OR:  rw_data = a_reg | b_reg;
                            A_AND: rw_data = a_reg & b_reg;
                            A_XOR: rw_data = a_reg ^ b_reg;
                            A_ADD:
                            begin
                                rw_data = sum9[7:0];
                                vf_data = {7'd0, sum9[8]};
                                vf_en   = 1'b1;
                            end
                            A_SUB:
                            begin
                                rw_data = a_reg - b_reg;
                                vf_data = {7'd0, a_reg > b_reg};
                                vf_en   = 1'b1;
                            end
                            A_SHR:
                            begin
                                rw_data = {1'b0, a_reg[7:1]};
                                vf_data = {7'd0, a_reg[0]};
                                vf_en   = 1'b1;
                            end
                            A_SBN:
                            begin
                                rw_data = b_reg - a_reg;
                                vf_data = {7'd0, b_reg > a_reg};
                                vf_en   = 1'b1;
                            end
                            A_SHL:
                            begin
                                rw_data = {a_reg[6:0], 1'b0};
                                vf_data = {7'd0, a_reg[7]};
                                vf_en   = 1'b1;
                            end
                            default: rw_en = 1'b0;
                        endcase
                    end
                    N_SNER: if (a_reg != b_reg) pc_next = pc_reg + 12'd2;
                    N_LDX:  idx_next = nnn;
                    N_JPV:  pc_next = nnn + {4'd0, b_reg};
                    N_RND:
                    begin
                        rw_en   = 1'b1;
                        rw_data = rnd_reg & kk;
                    end
                    N_KEY:
                    begin
                        if (kk == K_SKP && key_hit)
                            pc_next = pc_reg + 12'd2;
                        else if (kk == K_SKNP && !key_hit)
                            pc_next = pc_reg + 12'd2;
                    end
                    N_MISC:
                    begin
                        case (kk)
                            K_GDT:
                            begin
                                rw_en   = 1'b1;
                                rw_data = dt_reg;
                            end
                            K_WKEY:
                            begin
                                if (key_found)
                                begin
                                    rw_en   = 1'b1;
                                    rw_data = {4'd0, low_key};
                                end
                                else
                                begin
                                    pc_next  = pc_reg - 12'd2;
                                    wait_set = 1'b1;
                                end
                            end
                            K_SDT:   dt_next = a_reg;
                            K_SST:   st_next = a_reg;
                            K_ADDX:  idx_next = idx_reg + {4'd0, a_reg};
                            K_FONT:  idx_next = {2'd0, a_reg, 2'd0} + {4'd0, a_reg};
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            U_LD1:
            begin
                rw_en   = 1'b1;
                rw_addr = cnt_reg[3:0];
                rw_data = mem_q;
            end
            U_SPRF:
            begin
                vf_en   = 1'b1;
                vf_data = {7'd0, hit_reg};
            end
            U_TICK:
            begin
                if (dt_reg != 8'd0)
                    dt_next = dt_reg - 8'd1;
                if (st_reg != 8'd0)
                    st_next = st_reg - 8'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= 12'd0;
            pc_reg   <= START_ADDR;
            idx_reg  <= 12'd0;
            sp_reg   <= 4'd0;
            dt_reg   <= 8'd0;
            st_reg   <= 8'd0;
            cnt_reg  <= 5'd0;
            hit_reg  <= 1'b0;
            draw_reg <= 1'b0;
            wait_reg <= 1'b0;
            row_reg  <= 64'd0;
            for (int i = 0; i < 16; i++)
                regs_reg[i] <= 8'd0;
            for (int i = 0; i < STACK_DEPTH; i++)
                stack_reg[i] <= 12'd0;
        end
        else
        begin
            pc_reg  <= pc_next;
            idx_reg <= idx_next;
            sp_reg  <= sp_next;
            dt_reg  <= dt_next;
            st_reg  <= st_next;
            if (cmd.uop == U_CLR)
                clr_reg <= clr_reg + 12'd1;
            if (push)
                stack_reg[sp_reg] <= pc_reg;
            // flag first, result second so vx wins when x is the flag register
            if (vf_en && !(rw_en && rw_addr == 4'd15))
                regs_reg[15] <= vf_data;
            if (rw_en)
                regs_reg[rw_addr] <= rw_data;
            if (cmd.latch)
            begin
                row_reg  <= 64'd0;
                draw_reg <= 1'b0;
                wait_reg <= 1'b0;
            end
            if (wait_set)
                wait_reg <= 1'b1;
            case (cmd.uop)
                U_RROW1: row_reg <= fb_q;
                U_F4:
                begin
                    cnt_reg <= 5'd0;
                    hit_reg <= 1'b0;
                end
                U_CLS:
                begin
                    cnt_reg  <= cnt_reg + 5'd1;
                    draw_reg <= 1'b1;
                end
                U_BCD, U_STO, U_LD1: cnt_reg <= cnt_reg + 5'd1;
                U_SPR1:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if ((fb_q & mask) != 64'd0)
                        hit_reg <= 1'b1;
                end
                U_SPRF:  draw_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            addr_reg <= address;
            data_reg <= data;
            keys_reg <= keys;
            rnd_reg  <= random_byte;
        end
        if (cmd.uop == U_F1)
            op_reg[15:8] <= mem_q;
        if (cmd.uop == U_F2)
            op_reg[7:0] <= mem_q;
        if (cmd.uop == U_F3)
            a_reg <= rd_data;
        if (cmd.uop == U_F4)
            b_reg <= rd_data;
    end

endmodule

`default_nettype wire

@@ sv/chip8_interpreter_core_top.sv @@
// ----------------------------------------------------------------------------
// chip8_interpreter_core_top
// CHIP-8 core: loads program bytes, steps instructions, reads display rows.
//
//   channel  dir  contents
//   req      in   operation, address, data, keys, random_byte
//   rsp      out  display_row, program_counter, draw_done, sound_on, waiting_key
//
// one request at a time. a step fetches the two opcode bytes, reads vx and vy,
// then executes; screen clear, sprite draw, bcd and register block store/load
// loop over rows, digits or registers first. the timers tick at step end.
// after reset a clearing pass writes the font and zeros into memory and
// clears the frame buffer before the first request is taken. a result
// waits in the output register until taken; no new request is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module chip8_interpreter_core_top (
    input wire logic   clk,
    input wire logic   rst_n,
    c8ic_req_if.sink   req,
    c8ic_rsp_if.source rsp
);
    import c8ic_pkg::*;

    cmd_t cmd;
    sts_t sts;

    c8ic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    c8ic_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .operation       (req.operation),
        .address         (req.address),
        .data            (req.data),
        .keys            (req.keys),
        .random_byte     (req.random_byte),
        .display_row     (rsp.display_row),
        .program_counter (rsp.program_counter),
        .draw_done       (rsp.draw_done),
        .sound_on        (rsp.sound_on),
        .waiting_key     (rsp.waiting_key)
    );

endmodule

`default_nettype wire

@@ test/c8ic_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ic_checker
// Watches the request and result channels of the chip8 interpreter core,
// keeps its own copy of the machine state, predicts the result of every
// accepted request and compares each accepted result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module c8ic_checker
    import c8ic_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    c8ic_req_if       req,
    c8ic_rsp_if       rsp,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic [63:0] row;
        logic [11:0] pc;
        logic        drew;
        logic        snd;
        logic        wkey;
    } core_result_t;

    logic [7:0]  mem_model [MEM_BYTES];
    logic [7:0]  vreg [16];
    logic [11:0] call_stack [STACK_DEPTH];
    logic [3:0]  sp;
    logic [11:0] pc;
    logic [11:0] ireg;
    logic [7:0]  delay_t;
    logic [7:0]  sound_t;
    logic [63:0] screen [SCREEN_HEIGHT];

    core_result_t result_q [$];

    assign pending = result_q.size();

    task automatic reset_machine();
        for (int a = 0; a < MEM_BYTES; a++)
            mem_model[a] = (a < FONT_BYTES) ? FONT_ROM[a] : 8'h00;
        for (int r = 0; r < 16; r++)
        begin
            vreg[r]       = '0;
            call_stack[r] = '0;
        end
        for (int r = 0; r < SCREEN_HEIGHT; r++)
            screen[r] = '0;
        sp      = '0;
        pc      = START_ADDR;
        ireg    = '0;
        delay_t = '0;
        sound_t = '0;
    endtask

    task automatic draw(input logic [7:0] vx, input logic [7:0] vy, input logic [3:0] n);
        int          x0;
        int          y0;
        int          yy;
        int          xx;
        logic [7:0]  bits;
        logic [63:0] m;
        logic        hit;
        x0  = vx % SCREEN_WIDTH;
        y0  = vy % SCREEN_HEIGHT;
        hit = 1'b0;
        for (int r = 0; r < n; r++)
        begin
            yy = y0 + r;
            if (yy >= SCREEN_HEIGHT)
                break;
            bits = mem_model[12'(ireg + r)];
            for (int c = 0; c < 8; c++)
            begin
                xx = x0 + c;
                if (xx >= SCREEN_WIDTH)
                    break;
                if (bits[7-c])
                begin
                    m = 64'd1 << (63 - xx);
                    if ((screen[yy] & m) != 0)
                        hit = 1'b1;
                    screen[yy] ^= m;
                end
            end
        end
        vreg[15] = {7'd0, hit};
    endtask

    task automatic run_instruction(input logic [15:0] keys, input logic [7:0] rnd,
                                   output logic drew, output logic wkey);
        logic [15:0] op;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  kk;
        logic [7:0]  a;
        logic [7:0]  b;
        logic        found;
        op   = {mem_model[pc], mem_model[12'(pc + 1)]};
        x    = op[11:8];
        y    = op[7:4];
        kk   = op[7:0];
        drew = 1'b0;
        wkey = 1'b0;
        pc   = pc + 12'd2;
        case (op[15:12])
            N_SYS:
                if (kk == K_CLS)
                begin
                    for (int r = 0; r < SCREEN_HEIGHT; r++)
                        screen[r] = '0;
                    drew = 1'b1;
                end
                else if (kk == K_RET)
                begin
                    sp = sp - 4'd1;
                    pc = call_stack[sp];
                end
            N_JP:   pc = op[11:0];
            N_CALL:
            begin
                call_stack[sp] = pc;
                sp = sp + 4'd1;
                pc = op[11:0];
            end
            N_SEI:  if (vreg[x] == kk) pc = pc + 12'd2;
            N_SNEI: if (vreg[x] != kk) pc = pc + 12'd2;
            N_SER:  if (vreg[x] == vreg[y]) pc = pc + 12'd2;
            N_LDI:  vreg[x] = kk;
            N_ADDI: vreg[x] = vreg[x] + kk;
            N_ALU:
            begin
                a = vreg[x];
                b = vreg[y];
                case (op[3:0])
                    A_MOV: vreg[x] = b;
                    A_OR:  vreg[x] = a | b;
                    A_AND: vreg[x] = a & b;
                    A_XOR: vreg[x] = a ^ b;
                    A_ADD:
                    begin
                        vreg[15] = ({1'b0, a} + {1'b0, b} > 9'd255) ? 8'd1 : 8'd0;
                        vreg[x]  = a + b;
                    end
                    A_SUB:
                    begin
                        vreg[15] = (a > b) ? 8'd1 : 8'd0;
                        vreg[x]  = a - b;
                    end
                    A_SHR:
                    begin
                        vreg[15] = {7'd0, a[0]};
                        vreg[x]  = a >> 1;
                    end
                    A_SBN:
                    begin
                        vreg[15] = (b > a) ? 8'd1 : 8'd0;
                        vreg[x]  = b - a;
                    end
                    A_SHL:
                    begin
                        vreg[15] = {7'd0, a[7]};
                        vreg[x]  = a << 1;
                    end
                    default: ;
                endcase
            end
            N_SNER: if (vreg[x] != vreg[y]) pc = pc + 12'd2;
            N_LDX:  ireg = op[11:0];
            N_JPV:  pc = op[11:0] + {4'd0, vreg[0]};
            N_RND:  vreg[x] = rnd & kk;
            N_DRW:
            begin
                draw(vreg[x], vreg[y], op[3:0]);
                drew = 1'b1;
            end
            N_KEY:
                // key numbers above 15 count as not pressed
                if (kk == K_SKP)
                begin
                    if (vreg[x] <= 8'd15 && keys[vreg[x][3:0]]) pc = pc + 12'd2;
                end
                else if (kk == K_SKNP)
                begin
                    if (!(vreg[x] <= 8'd15 && keys[vreg[x][3:0]])) pc = pc + 12'd2;
                end
            default:
                case (kk)
                    K_GDT: vreg[x] = delay_t;
                    K_WKEY:
                    begin
                        found = 1'b0;
                        for (int k = 0; k < 16; k++)
                            if (!found && keys[k])
                            begin
                                vreg[x] = 8'(k);
                                found   = 1'b1;
                            end
                        if (!found)
                        begin
                            pc   = pc - 12'd2;
                            wkey = 1'b1;
                        end
                    end
                    K_SDT:  delay_t = vreg[x];
                    K_SST:  sound_t = vreg[x];
                    K_ADDX: ireg = ireg + {4'd0, vreg[x]};
                    K_FONT: ireg = 12'(vreg[x] * 5);
                    K_BCD:
                    begin
                        mem_model[ireg]           = vreg[x] / 100;
                        mem_model[12'(ireg + 1)]  = (vreg[x] / 10) % 10;
                        mem_model[12'(ireg + 2)]  = vreg[x] % 10;
                    end
                    K_STO:
                        for (int r = 0; r <= x; r++)
                            mem_model[12'(ireg + r)] = vreg[r];
                    K_LDM:
                        for (int r = 0; r <= x; r++)
                            vreg[r] = mem_model[12'(ireg + r)];
                    default: ;
                endcase
        endcase
        if (delay_t != 0) delay_t = delay_t - 8'd1;
        if (sound_t != 0) sound_t = sound_t - 8'd1;
    endtask

    task automatic predict_request();
        core_result_t e;
        e = '0;
        case (req.operation)
            OP_LOAD: mem_model[req.address] = req.data;
            OP_STEP: run_instruction(req.keys, req.random_byte, e.drew, e.wkey);
            OP_READ: e.row = screen[req.address[ROW_W-1:0]];
            default: ;
        endcase
        e.pc  = pc;
        e.snd = (sound_t != 0);
        result_q.push_back(e);
    endtask

    task automatic check_result();
        core_result_t e;
        core_result_t got;
        got = {rsp.display_row, rsp.program_counter, rsp.draw_done, rsp.sound_on,
               rsp.waiting_key};
        if (result_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: result with no request outstanding: %h", $realtime, got);
            return;
        end
        e = result_q.pop_front();
        if (got !== e)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: row exp %h got %h, pc exp %h got %h, draw %b/%b snd %b/%b wait %b/%b",
                         $realtime, e.row, got.row, e.pc, got.pc, e.drew, got.drew,
                         e.snd, got.snd, e.wkey, got.wkey);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_machine();
            result_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_result();
            if (req.valid && req.ready)
                predict_request();
        end
    end

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the chip8 interpreter core with short programs loaded in front of
// the program counter and then stepped, plus row reads and stray requests,
// under varying idle patterns on both channels; the checker does the scoring.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import c8ic_pkg::*;

    localparam int STALL_LIMIT = 60000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   sent;
    int   idle_pct;
    int   stall_pct;
    int   quiet;
    logic [11:0] last_pc;

    c8ic_req_if req ();
    c8ic_rsp_if rsp ();

    chip8_interpreter_core_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    c8ic_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(negedge clk)
        rsp.ready = ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            last_pc <= rsp.program_counter;
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(input logic [1:0] op, input logic [11:0] addr,
                        input logic [7:0] dat, input logic [15:0] keys, input logic [7:0] rnd);
        while ($urandom_range(99) < idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid       = 1'b1;
        req.operation   = op;
        req.address     = addr;
        req.data        = dat;
        req.keys        = keys;
        req.random_byte = rnd;
        // ready only changes at the rising edge, so a high ready here means
        // the request is taken at the next rising edge
        while (!req.ready)
            @(negedge clk);
        @(negedge clk);
        req.valid = 1'b0;
        sent++;
    endtask

    task automatic step(input logic [15:0] keys);
        send(OP_STEP, 12'($urandom), 8'($urandom), keys, 8'($urandom));
    endtask

    task automatic put_word(input logic [11:0] addr, input logic [15:0] w);
        send(OP_LOAD, addr, w[15:8], 16'($urandom), 8'($urandom));
        send(OP_LOAD, addr + 12'd1, w[7:0], 16'($urandom), 8'($urandom));
    endtask

    task automatic settle();
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [15:0] random_instr();
        logic [3:0]  nib;
        logic [15:0] w;
        logic [3:0]  alu_ops [9] = '{A_MOV, A_OR, A_AND, A_XOR, A_ADD, A_SUB, A_SHR,
                                     A_SBN, A_SHL};
        logic [7:0]  misc [13] = '{K_GDT, K_WKEY, K_SDT, K_SST, K_ADDX, K_FONT, K_BCD,
                                   K_STO, K_LDM, K_GDT, K_SDT, K_SST, K_FONT};
        nib = 4'($urandom);
        w   = {nib, 12'($urandom)};
        case (nib)
            N_SYS:
                case ($urandom_range(3))
                    0: w = {8'h00, K_CLS};
                    1: w = {8'h00, K_RET};
                    default: ;
                endcase
            N_ALU:
                if ($urandom_range(9) != 0)
                    w[3:0] = alu_ops[$urandom_range(8)];
            N_KEY:
                if ($urandom_range(5) != 0)
                    w[7:0] = $urandom_range(1) ? K_SKP : K_SKNP;
            N_MISC:
                if ($urandom_range(9) != 0)
                    w[7:0] = misc[$urandom_range(12)];
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        logic [15:0] prog [$];
        logic [11:0] base;
        int          len;

        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.operation   = OP_LOAD;
        req.address     = '0;
        req.data        = '0;
        req.keys        = '0;
        req.random_byte = '0;
        rsp.ready       = 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        sent            = 0;
        quiet           = 0;
        last_pc         = START_ADDR;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed program: alu flags, font sprite draw with clipping and
        // collision, bcd, block store/load, call/return, key wait
        prog = '{16'h60FF, 16'h6101, 16'h8014, 16'h8F15, 16'h8106, 16'h800E,
                 16'h6A3D, 16'h6B1E, 16'hF029, 16'hDAB5, 16'hDAB5, 16'h00E0,
                 16'hA300, 16'hF033, 16'hFF55, 16'hFF65, 16'h2400, 16'h62C8,
                 16'hF218, 16'hF10A, 16'h3000, 16'hBFFF};
        foreach (prog[k])
            put_word(START_ADDR + 12'(2 * k), prog[k]);
        put_word(12'h400, {8'h00, K_RET});
        for (int k = 0; k < 12; k++)
            step(16'hFFFF);
        send(OP_READ, 12'hFFE, 8'hFF, 16'hFFFF, 8'hFF);
        step(16'hFFFF);
        send(OP_READ, 12'h01E, 8'h00, 16'h0000, 8'h00);
        for (int k = 0; k < 7; k++)
            step(16'h8000);
        step(16'h0000);
        step(16'h0000);
        send(2'd3, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
        send(OP_LOAD, 12'hFFF, 8'h5A, 16'h0000, 8'h00);

        // random: write a few instructions at pc, then run them
        while (sent < 515)
        begin
            case ((sent / 70) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            settle();
            repeat (2) @(negedge clk);
            base = last_pc;
            len  = $urandom_range(1, 5);
            for (int k = 0; k < len; k++)
                put_word(base + 12'(2 * k), random_instr());
            for (int k = 0; k < len; k++)
                step(($urandom_range(4) == 0) ? 16'h0000 : 16'($urandom));
            case ($urandom_range(5))
                0: send(OP_READ, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
                1: send(2'd3, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
                2: send(OP_LOAD, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
                default: ;
            endcase
        end
        for (int r = 0; r < SCREEN_HEIGHT; r++)
            send(OP_READ, 12'(r), 8'($urandom), 16'($urandom), 8'($urandom));

        stall_pct = 0;
        settle();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

@@ chip8_interpreter_core_top.f @@
sv/c8ic_pkg.sv
sv/c8ic_if.sv
sv/c8ic_ctrl.sv
sv/c8ic_dp.sv
sv/chip8_interpreter_core_top.sv
test/c8ic_checker.sv
test/tb.sv
